[sv/lsno_pkg.sv]
// Shared types, constants and arithmetic helpers of the looping simplex noise oscillator.
package lsno_pkg;

  localparam int MaxColumnsDef    = 16;
  localparam int PhaseFracBitsDef = 20;

  localparam int StepW   = 24;
  localparam int EvolW   = 20;
  localparam int SampleW = 24;
  localparam int RecipW  = 27;
  localparam int LaneW   = 16;
  localparam int NumLanes = 8;

  localparam logic [LaneW-1:0] LfsrTaps = 16'h100B;

  localparam longint Sqrt3Q24        = 64'sd29058991;
  localparam longint ThreeQuarterQ30 = 64'sd805306368;
  localparam logic [63:0] NormNum    = 64'd12000000000000;
  localparam logic [63:0] NormC      = 64'd1247338367;

  localparam logic [1:0] RegCycleLen  = 2'd0;
  localparam logic [1:0] RegHarmMask  = 2'd1;
  localparam logic [1:0] RegSeedLow   = 2'd2;
  localparam logic [1:0] RegSeedHigh  = 2'd3;

  typedef struct packed {
    logic start;
    logic clr;
  } mac_req_t;

  typedef struct packed {
    logic go;
    logic init;
  } grid_cmd_t;

  // Sine of (2a+1)*pi/16 in Q1.15.
  function automatic logic signed [15:0] sine_q15(input logic [3:0] a);
    logic signed [15:0] s;
    unique case (a)
      4'd0:    s = 16'sd6393;
      4'd1:    s = 16'sd18205;
      4'd2:    s = 16'sd27246;
      4'd3:    s = 16'sd32138;
      4'd4:    s = 16'sd32138;
      4'd5:    s = 16'sd27246;
      4'd6:    s = 16'sd18205;
      4'd7:    s = 16'sd6393;
      4'd8:    s = -16'sd6393;
      4'd9:    s = -16'sd18205;
      4'd10:   s = -16'sd27246;
      4'd11:   s = -16'sd32138;
      4'd12:   s = -16'sd32138;
      4'd13:   s = -16'sd27246;
      4'd14:   s = -16'sd18205;
      default: s = -16'sd6393;
    endcase
    return s;
  endfunction

  // Q30 weight of harmonic layer e (1 to 5 for the 2x, 3x, 4x, 5x and 8x layers).
  function automatic logic signed [31:0] harm_w_q30(input logic [2:0] e);
    logic signed [31:0] w;
    unique case (e)
      3'd1:    w = 32'sd536870912;
      3'd2:    w = 32'sd357913941;
      3'd3:    w = 32'sd268435456;
      3'd4:    w = 32'sd214748365;
      3'd5:    w = 32'sd134217728;
      default: w = 32'sd0;
    endcase
    return w;
  endfunction

  // Total weight times 120 for a given harmonic enable mask.
  function automatic int harm_w120(input int m);
    int w;
    w = 120;
    if (m % 2 == 1)       w = w + 60;
    if ((m / 2) % 2 == 1) w = w + 40;
    if ((m / 4) % 2 == 1) w = w + 30;
    if ((m / 8) % 2 == 1) w = w + 24;
    if ((m / 16) % 2 == 1) w = w + 15;
    return w;
  endfunction

  function automatic logic [LaneW-1:0] lfsr_next(input logic [LaneW-1:0] v);
    logic [LaneW-1:0] n;
    n = v << 1;
    if (v[LaneW-1]) n = n ^ LfsrTaps;
    return n;
  endfunction

  // Round half up, then arithmetic shift right by s.
  function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

endpackage

[sv/lsno_mac.sv]
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
module lsno_mac
  import lsno_pkg::*;
#(
  parameter int AW = 64,
  parameter int BW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_req_t             req_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW-1:0] acc_o,
  output logic                 busy_o
);

  localparam int CntW = $clog2(BW);

  logic signed [AW-1:0] a_q, acc_q, term;
  logic        [BW-1:0] b_q;
  logic      [CntW-1:0] cnt_q;
  logic                 busy_q;

  assign term = b_q[0] ? a_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(BW - 1)) busy_q <= 1'b0;
    end
  end

  // The top multiplier bit carries negative weight.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= a_i;
      b_q <= b_i;
      if (req_i.clr) acc_q <= '0;
    end else if (busy_q) begin
      a_q <= a_q <<< 1;
      b_q <= b_q >> 1;
      if (cnt_q == CntW'(BW - 1)) acc_q <= acc_q - term;
      else                        acc_q <= acc_q + term;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = busy_q;

endmodule

[sv/lsno_grid.sv]
// Gradient angle rows and the eight LFSR lanes that draw new rows.
module lsno_grid
  import lsno_pkg::*;
#(
  parameter int MAX_COLUMNS = MaxColumnsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  grid_cmd_t                      cmd_i,
  input  logic [63:0]                    seed_low_i,
  input  logic [63:0]                    seed_high_i,
  input  logic                           rd_row_i,
  input  logic [$clog2(MAX_COLUMNS)-1:0] rd_col_i,
  output logic [3:0]                     angle_o,
  output logic                           busy_o
);

  localparam int NBlk = (MAX_COLUMNS + 7) / 8;
  localparam int BkW  = (NBlk > 1) ? $clog2(NBlk) : 1;

  logic [LaneW-1:0] lane_q [NumLanes];
  logic [3:0]       upper_q [MAX_COLUMNS];
  logic [3:0]       lower_q [MAX_COLUMNS];
  logic             busy_q, extra_q;
  logic [2:0]       stp_q;
  logic [BkW-1:0]   blk_q;
  logic             adv, wr, last_blk;

  assign adv      = busy_q && (stp_q != 3'd4);
  assign wr       = busy_q && (stp_q == 3'd4);
  assign last_blk = (blk_q == BkW'(NBlk - 1));

  // A row is drawn as four lane advances followed by one write, per block of eight columns.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      extra_q <= 1'b0;
      stp_q   <= '0;
      blk_q   <= '0;
    end else if (cmd_i.go) begin
      busy_q  <= 1'b1;
      extra_q <= cmd_i.init;
      stp_q   <= '0;
      blk_q   <= '0;
    end else if (busy_q) begin
      if (!wr) begin
        stp_q <= stp_q + 3'd1;
      end else begin
        stp_q <= '0;
        if (last_blk) begin
          blk_q <= '0;
          if (extra_q) extra_q <= 1'b0;
          else         busy_q  <= 1'b0;
        end else begin
          blk_q <= blk_q + 1'b1;
        end
      end
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (cmd_i.go && cmd_i.init) begin
        if (l < 4) begin
          lane_q[l] <= (seed_low_i[16*(l%4) +: 16] == '0) ? 16'd1 : seed_low_i[16*(l%4) +: 16];
        end else begin
          lane_q[l] <= (seed_high_i[16*(l%4) +: 16] == '0) ? 16'd1 :
                       seed_high_i[16*(l%4) +: 16];
        end
      end else if (adv) begin
        lane_q[l] <= lfsr_next(lane_q[l]);
      end
    end
  end

  for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_col
    logic       hit;
    logic [3:0] new_ang;
    assign hit     = wr && (blk_q == BkW'(c / 8));
    assign new_ang = lane_q[c % 8][3:0];
    always_ff @(posedge clk_i) begin
      if (hit) upper_q[c] <= new_ang;
      if (cmd_i.go && !cmd_i.init) begin
        lower_q[c] <= upper_q[c];
      end else if (wr && last_blk && extra_q) begin
        // Copy-down right after the first row of a fill sees this cycle's writes.
        lower_q[c] <= hit ? new_ang : upper_q[c];
      end
    end
  end

  assign angle_o = rd_row_i ? upper_q[rd_col_i] : lower_q[rd_col_i];
  assign busy_o  = busy_q;

endmodule

[sv/looping_simplex_noise_oscillator.sv]
// Top level of the looping 2-D simplex noise oscillator.
//
// Usage: each input transaction (phase_step_i, evol_step_i) is one audio tick and
// yields exactly one output transaction carrying sample_o, in order. Both channels
// move a transaction at a rising edge where valid is high and stall is low.
// The block works on one tick at a time. Every multiply runs on a shared bit-serial
// multiply-accumulate unit and holds the sequencer until it is done, and a corner
// of the simplex cell needs up to eight of them. A tick evaluates the base noise
// plus one more noise per enabled harmonic layer, then runs the normalising
// multiply; a tick that crosses an evolution wrap also draws a gradient row, and
// the very first tick after reset first fills both rows from the seed registers.
// Integer reduction of the phase and of each cell index runs one bit per cycle.
// Reset clears phase, evolution and the grid-ready flag and returns the control
// and configuration registers to their reset values; the datapath registers have
// no reset. A finished sample sits in the output register while the next tick is
// already accepted and computed; if the receiver stalls, the following sample
// waits internally until the output register is free.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write it only while idle, as the block itself does not enforce this.
module looping_simplex_noise_oscillator
  import lsno_pkg::*;
#(
  parameter int MAX_COLUMNS     = MaxColumnsDef,
  parameter int PHASE_FRAC_BITS = PhaseFracBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [63:0]               cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [StepW-1:0]          phase_step_i,
  input  logic [EvolW-1:0]          evol_step_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] sample_o
);

  localparam int PFB  = PHASE_FRAC_BITS;
  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int LW   = $clog2(MAX_COLUMNS + 1);
  localparam int PW   = PFB + CW;
  localparam int SW   = ((PW > StepW) ? PW : StepW) + 1;
  localparam int IPW  = SW - PFB;
  localparam int RW   = (IPW > CW + 3) ? IPW : CW + 3;
  localparam int RCW  = $clog2(RW);
  localparam int POSW = PW + 3;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_GWAIT  = 11'b00000000010,
    ST_PHASE  = 11'b00000000100,
    ST_PMOD   = 11'b00000001000,
    ST_EVO    = 11'b00000010000,
    ST_EVAL   = 11'b00000100000,
    ST_CMOD   = 11'b00001000000,
    ST_CORNER = 11'b00010000000,
    ST_MSTART = 11'b00100000000,
    ST_MWAIT  = 11'b01000000000,
    ST_EMIT   = 11'b10000000000
  } state_e;

  typedef enum logic [3:0] {
    OP_PY, OP_PX2, OP_PY2, OP_DOTX, OP_DOTY, OP_T2, OP_T4, OP_CRN, OP_HARM, OP_NORM
  } op_e;

  // Configuration registers.
  logic [4:0]  cyc_len_q, hmask_q;
  logic [63:0] seed_lo_q, seed_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_len_q <= 5'd4;
      hmask_q   <= '0;
      seed_lo_q <= 64'h0001_0001_0001_0001;
      seed_hi_q <= 64'h0001_0001_0001_0001;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCycleLen: cyc_len_q <= cfg_data_i[4:0];
        RegHarmMask: hmask_q   <= cfg_data_i[4:0];
        RegSeedLow:  seed_lo_q <= cfg_data_i;
        RegSeedHigh: seed_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Normaliser reciprocals, one per harmonic mask, worked out at elaboration.
  logic [RecipW-1:0] recip_tab [32];
  for (genvar m = 0; m < 32; m++) begin : g_recip
    localparam logic [63:0] Den = NormC * 64'(harm_w120(m));
    localparam logic [63:0] Rcp = ((NormNum << 20) + Den / 2) / Den;
    assign recip_tab[m] = RecipW'(Rcp);
  end

  // Control state.
  state_e         state_q, state_d;
  op_e            op_q, op_d;
  logic           grid_ready_q, grid_ready_d;
  logic [LW-1:0]  len_q, len_d;
  logic           out_valid_q;
  logic           pass_q, pass_d;
  logic [RCW-1:0] rcnt_q, rcnt_d;
  logic [2:0]     e_q, e_d;
  logic [1:0]     cidx_q, cidx_d;

  // Datapath registers.
  logic [StepW-1:0]          step_q, step_d;
  logic [EvolW-1:0]          estep_q, estep_d, evo_q, evo_d;
  logic [PW-1:0]             phase_q, phase_d;
  logic [RW-1:0]             dvd_q, dvd_d;
  logic [CW-1:0]             rem_q, rem_d, cell_q, cell_d, right_q, right_d;
  logic [PFB-1:0]            frac_q, frac_d;
  logic [3:0]                ang_q, ang_d;
  logic signed [27:0]        px_q, px_d;
  logic signed [25:0]        dy_q, dy_d, py_q, py_d;
  logic signed [33:0]        t_q, t_d, dot_q, dot_d;
  logic signed [35:0]        noise_q, noise_d;
  logic signed [37:0]        total_q, total_d;
  logic signed [SampleW-1:0] res_q, res_d, out_q;
  logic                      out_load;

  // Submodule links.
  mac_req_t           mac_req;
  logic signed [63:0] mac_a, mac_acc;
  logic signed [31:0] mac_b;
  logic               mac_busy;
  grid_cmd_t          grid_cmd;
  logic               grid_busy;
  logic [CW-1:0]      rd_col;
  logic [3:0]         grid_ang;

  lsno_mac #(.AW(64), .BW(32)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc),
    .busy_o (mac_busy)
  );

  assign rd_col = cidx_q[0] ? right_q : cell_q;

  lsno_grid #(.MAX_COLUMNS(MAX_COLUMNS)) u_grid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (grid_cmd),
    .seed_low_i  (seed_lo_q),
    .seed_high_i (seed_hi_q),
    .rd_row_i    (cidx_q[1]),
    .rd_col_i    (rd_col),
    .angle_o     (grid_ang),
    .busy_o      (grid_busy)
  );

  // Clamped cycle length from the register.
  logic [LW-1:0] len_clamp;
  always_comb begin
    if (cyc_len_q < 5'd2)                 len_clamp = LW'(2);
    else if (int'(cyc_len_q) > MAX_COLUMNS) len_clamp = LW'(MAX_COLUMNS);
    else                                    len_clamp = LW'(cyc_len_q);
  end

  // One restoring step of the serial remainder unit.
  logic [CW:0]   r_ext;
  logic [CW-1:0] r_new;
  logic [CW:0]   nxt_col;
  always_comb begin
    r_ext = {rem_q, dvd_q[RW-1]};
    if (r_ext >= (CW+1)'(len_q)) r_new = CW'(r_ext - (CW+1)'(len_q));
    else                         r_new = CW'(r_ext);
    nxt_col = (CW+1)'(r_new) + 1'b1;
  end

  // Sample position of the current layer.
  logic [POSW-1:0] p_ext, pos;
  always_comb begin
    p_ext = POSW'(phase_q);
    unique case (e_q)
      3'd1:    pos = p_ext << 1;
      3'd2:    pos = p_ext + (p_ext << 1);
      3'd3:    pos = p_ext << 2;
      3'd4:    pos = p_ext + (p_ext << 2);
      3'd5:    pos = p_ext << 3;
      default: pos = p_ext;
    endcase
  end

  logic layer_en;
  assign layer_en = (e_q == 3'd0) || hmask_q[3'(e_q - 3'd1)];

  // Corner offsets in Q24.
  logic [23:0]        u_c, y_c;
  logic signed [25:0] dx_c, dy_c;
  logic signed [27:0] px_c;
  always_comb begin
    u_c  = 24'(frac_q) << (24 - PFB);
    y_c  = {evo_q, 4'b0000};
    dx_c = cidx_q[0] ? $signed({2'b00, u_c}) - 26'sd16777216 : $signed({2'b00, u_c});
    dy_c = cidx_q[1] ? $signed({2'b00, y_c}) - 26'sd16777216 : $signed({2'b00, y_c});
    px_c = (28'(dx_c) <<< 1) - 28'(dy_c);
  end

  // Multiplier operands per operation.
  always_comb begin
    mac_a = 64'(px_q);
    mac_b = 32'(px_q);
    mac_req.start = (state_q == ST_MSTART);
    mac_req.clr   = 1'b1;
    unique case (op_q)
      OP_PY:   begin mac_a = Sqrt3Q24;        mac_b = 32'(dy_q); end
      OP_PX2:  begin mac_a = 64'(px_q);       mac_b = 32'(px_q); end
      OP_PY2:  begin mac_a = 64'(py_q);       mac_b = 32'(py_q); mac_req.clr = 1'b0; end
      OP_DOTX: begin mac_a = 64'(px_q);       mac_b = 32'(sine_q15(ang_q)); end
      OP_DOTY: begin
        mac_a = 64'(py_q);
        mac_b = 32'(sine_q15(4'(ang_q + 4'd4)));
        mac_req.clr = 1'b0;
      end
      OP_T2, OP_T4: begin mac_a = 64'(t_q);  mac_b = 32'(t_q); end
      OP_CRN:  begin mac_a = 64'(dot_q);      mac_b = 32'(t_q); end
      OP_HARM: begin mac_a = 64'(noise_q);    mac_b = harm_w_q30(e_q); end
      OP_NORM: begin
        mac_a = 64'(total_q);
        mac_b = 32'($signed({1'b0, recip_tab[hmask_q]}));
      end
      default: ;
    endcase
  end

  // Main sequencer.
  logic               corner_end, layer_end;
  logic signed [63:0] tv, sv;
  logic [SW-1:0]      psum;
  logic [EvolW:0]     esum;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    grid_ready_d = grid_ready_q;
    len_d        = len_q;
    pass_d       = pass_q;
    rcnt_d       = rcnt_q;
    e_d          = e_q;
    cidx_d       = cidx_q;
    step_d       = step_q;
    estep_d      = estep_q;
    evo_d        = evo_q;
    phase_d      = phase_q;
    dvd_d        = dvd_q;
    rem_d        = rem_q;
    cell_d       = cell_q;
    right_d      = right_q;
    frac_d       = frac_q;
    ang_d        = ang_q;
    px_d         = px_q;
    dy_d         = dy_q;
    py_d         = py_q;
    t_d          = t_q;
    dot_d        = dot_q;
    noise_d      = noise_q;
    total_d      = total_q;
    res_d        = res_q;
    out_load     = 1'b0;
    grid_cmd     = '0;
    corner_end   = 1'b0;
    layer_end    = 1'b0;
    tv           = ThreeQuarterQ30 - rsh(mac_acc, 20);
    sv           = rsh(mac_acc, 31);
    psum         = SW'(phase_q) + SW'(step_q);
    esum         = {1'b0, evo_q} + {1'b0, estep_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          step_d  = phase_step_i;
          estep_d = evol_step_i;
          if (!grid_ready_q) begin
            grid_cmd.go   = 1'b1;
            grid_cmd.init = 1'b1;
            state_d       = ST_GWAIT;
          end else begin
            state_d = ST_PHASE;
          end
        end
      end
      ST_GWAIT: begin
        if (!grid_busy) begin
          if (!grid_ready_q) begin
            grid_ready_d = 1'b1;
            len_d        = len_clamp;
            state_d      = ST_PHASE;
          end else begin
            e_d     = '0;
            state_d = ST_EVAL;
          end
        end
      end
      ST_PHASE: begin
        frac_d = psum[PFB-1:0];
        if (psum[SW-1:PFB] >= IPW'(len_q)) begin
          dvd_d   = RW'(psum[SW-1:PFB]);
          rem_d   = '0;
          rcnt_d  = '0;
          pass_d  = 1'b0;
          state_d = ST_PMOD;
        end else begin
          phase_d = PW'(psum);
          state_d = ST_EVO;
        end
      end
      ST_PMOD: begin
        rem_d  = r_new;
        dvd_d  = dvd_q << 1;
        rcnt_d = rcnt_q + 1'b1;
        if (rcnt_q == RCW'(RW - 1)) begin
          if (!pass_q) begin
            // Reduce by the old length, then again by the newly latched one.
            len_d  = len_clamp;
            dvd_d  = RW'(r_new);
            rem_d  = '0;
            rcnt_d = '0;
            pass_d = 1'b1;
          end else begin
            phase_d = {r_new, frac_q};
            state_d = ST_EVO;
          end
        end
      end
      ST_EVO: begin
        evo_d = esum[EvolW-1:0];
        if (esum[EvolW]) begin
          grid_cmd.go = 1'b1;
          state_d     = ST_GWAIT;
        end else begin
          e_d     = '0;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (layer_en) begin
          dvd_d   = RW'(pos >> PFB);
          frac_d  = pos[PFB-1:0];
          rem_d   = '0;
          rcnt_d  = '0;
          state_d = ST_CMOD;
        end else if (e_q == 3'd5) begin
          op_d    = OP_NORM;
          state_d = ST_MSTART;
        end else begin
          e_d = e_q + 3'd1;
        end
      end
      ST_CMOD: begin
        rem_d  = r_new;
        dvd_d  = dvd_q << 1;
        rcnt_d = rcnt_q + 1'b1;
        if (rcnt_q == RCW'(RW - 1)) begin
          cell_d  = r_new;
          // The right neighbour of the last active column wraps to column zero.
          right_d = (nxt_col >= (CW+1)'(len_q)) ? '0 : CW'(nxt_col);
          cidx_d  = '0;
          noise_d = '0;
          state_d = ST_CORNER;
        end
      end
      ST_CORNER: begin
        ang_d   = grid_ang;
        px_d    = px_c;
        dy_d    = dy_c;
        op_d    = OP_PY;
        state_d = ST_MSTART;
      end
      ST_MSTART: begin
        state_d = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (!mac_busy) begin
          state_d = ST_MSTART;
          unique case (op_q)
            OP_PY: begin
              py_d = 26'(rsh(mac_acc, 24));
              op_d = OP_PX2;
            end
            OP_PX2: op_d = OP_PY2;
            OP_PY2: begin
              t_d = 34'(tv);
              // Outside the kernel radius a corner adds nothing.
              if (tv <= 64'sd0) corner_end = 1'b1;
              else              op_d = OP_DOTX;
            end
            OP_DOTX: op_d = OP_DOTY;
            OP_DOTY: begin
              dot_d = 34'(rsh(mac_acc, 10));
              op_d  = OP_T2;
            end
            OP_T2: begin
              t_d  = 34'(rsh(mac_acc, 30));
              op_d = OP_T4;
            end
            OP_T4: begin
              t_d  = 34'(rsh(mac_acc, 30));
              op_d = OP_CRN;
            end
            OP_CRN: begin
              noise_d    = noise_q + 36'(rsh(mac_acc, 30));
              corner_end = 1'b1;
            end
            OP_HARM: begin
              total_d   = total_q + 38'(rsh(mac_acc, 30));
              layer_end = 1'b1;
            end
            OP_NORM: begin
              if (sv > 64'sd8388607)       res_d = 24'sh7FFFFF;
              else if (sv < -64'sd8388608) res_d = 24'sh800000;
              else                         res_d = 24'(sv);
              state_d = ST_EMIT;
            end
            default: ;
          endcase
          if (corner_end) begin
            if (cidx_q == 2'd3) begin
              if (e_q == 3'd0) begin
                total_d   = 38'(noise_d);
                layer_end = 1'b1;
              end else begin
                op_d = OP_HARM;
              end
            end else begin
              cidx_d  = cidx_q + 2'd1;
              state_d = ST_CORNER;
            end
          end
          if (layer_end) begin
            if (e_q == 3'd5) begin
              op_d = OP_NORM;
            end else begin
              e_d     = e_q + 3'd1;
              state_d = ST_EVAL;
            end
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_PY;
      grid_ready_q <= 1'b0;
      len_q        <= LW'(4);
      pass_q       <= 1'b0;
      rcnt_q       <= '0;
      e_q          <= '0;
      cidx_q       <= '0;
      phase_q      <= '0;
      evo_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      grid_ready_q <= grid_ready_d;
      len_q        <= len_d;
      pass_q       <= pass_d;
      rcnt_q       <= rcnt_d;
      e_q          <= e_d;
      cidx_q       <= cidx_d;
      phase_q      <= phase_d;
      evo_q        <= evo_d;
      if (out_load)                       out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    estep_q <= estep_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    cell_q  <= cell_d;
    right_q <= right_d;
    frac_q  <= frac_d;
    ang_q   <= ang_d;
    px_q    <= px_d;
    dy_q    <= dy_d;
    py_q    <= py_d;
    t_q     <= t_d;
    dot_q   <= dot_d;
    noise_q <= noise_d;
    total_q <= total_d;
    res_q   <= res_d;
    if (out_load) out_q <= res_q;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_o    = out_q;

`ifndef SYNTHESIS
  a_grid_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grid_cmd.go |-> !grid_busy)
    else $error("grid command issued while a row draw is running");

  a_mac_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_req.start |-> !mac_busy)
    else $error("multiply started while the previous one is running");

  a_phase_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && grid_ready_q) |-> (phase_q[PW-1:PFB] < len_q))
    else $error("phase integer part not below the active cycle length");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("sample written over one that was not taken");
`endif

endmodule

[test/lsno_checker.sv]
// Checker for the simplex noise oscillator: predicts every sample and compares it.
`timescale 1ns / 1ps
module lsno_checker
  import lsno_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [63:0]               cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [StepW-1:0]          phase_step_i,
  input  logic [EvolW-1:0]          evol_step_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [SampleW-1:0] sample_i,
  output int                        pending_o,
  output int                        errors_o,
  output int                        samples_o
);

  localparam int Cols = MaxColumnsDef;
  localparam int Frac = PhaseFracBitsDef;

  logic [4:0]       cyc_len_reg;
  logic [4:0]       harm_mask_reg;
  logic [63:0]      seed_lo_reg;
  logic [63:0]      seed_hi_reg;
  logic [63:0]      phase_acc;
  logic [63:0]      evol_acc;
  logic [15:0]      lanes[NumLanes];
  logic [3:0]       lower_row[Cols];
  logic [3:0]       upper_row[Cols];
  logic             grid_ok;
  logic [63:0]      live_len;
  logic [SampleW-1:0] sample_queue[$];

  assign pending_o = sample_queue.size();

  function automatic longint round_half_up(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint grad_sin(logic [3:0] a);
    case (a)
      4'd0, 4'd7:   return 6393;
      4'd1, 4'd6:   return 18205;
      4'd2, 4'd5:   return 27246;
      4'd3, 4'd4:   return 32138;
      4'd8, 4'd15:  return -6393;
      4'd9, 4'd14:  return -18205;
      4'd10, 4'd13: return -27246;
      default:      return -32138;
    endcase
  endfunction

  function automatic logic [63:0] clamp_cols(logic [4:0] v);
    if (v < 2) return 2;
    if (v > Cols) return Cols;
    return 64'(v);
  endfunction

  // Four LFSR advances per block of eight columns, then one angle per lane.
  function automatic void draw_upper_row();
    for (int b = 0; b < Cols; b += 8) begin
      for (int r = 0; r < 4; r++)
        for (int l = 0; l < NumLanes; l++)
          lanes[l] = lanes[l][15] ? ((lanes[l] << 1) ^ 16'h100B) : (lanes[l] << 1);
      for (int l = 0; l < NumLanes; l++)
        if (b + l < Cols) upper_row[b + l] = lanes[l][3:0];
    end
  endfunction

  function automatic void copy_rows_down();
    for (int c = 0; c < Cols; c++) lower_row[c] = upper_row[c];
  endfunction

  function automatic longint corner_term(longint dx, longint dy, logic [3:0] a);
    longint px, py, t, dot, t2, t4;
    px = 2 * dx - dy;
    py = round_half_up(dy * Sqrt3Q24, 24);
    t = ThreeQuarterQ30 - round_half_up(px * px + py * py, 20);
    if (t <= 0) return 0;
    dot = round_half_up(px * grad_sin(a) + py * grad_sin(a + 4'd4), 10);
    t2 = round_half_up(t * t, 30);
    t4 = round_half_up(t2 * t2, 30);
    return round_half_up(t4 * dot, 30);
  endfunction

  function automatic longint noise_value(logic [63:0] pos);
    logic [63:0] col_idx, right;
    longint u, y, one;
    col_idx = (pos >> Frac) % live_len;
    right = (col_idx + 1 >= live_len) ? 0 : col_idx + 1;
    u = longint'((pos & ((64'd1 << Frac) - 1)) << (24 - Frac));
    y = longint'(evol_acc << 4);
    one = 64'sd1 <<< 24;
    return corner_term(u, y, lower_row[col_idx]) + corner_term(u - one, y, lower_row[right])
         + corner_term(u, y - one, upper_row[col_idx])
         + corner_term(u - one, y - one, upper_row[right]);
  endfunction

  // Advances the oscillator by one tick and returns the sample it produces.
  function automatic logic [SampleW-1:0] next_sample(logic [63:0] step, logic [63:0] estep);
    logic [63:0] ip, w120, denom, recip;
    longint total, s, mul, wq;
    if (!grid_ok) begin
      for (int i = 0; i < 4; i++) begin
        lanes[i] = seed_lo_reg[16*i +: 16];
        lanes[i + 4] = seed_hi_reg[16*i +: 16];
      end
      for (int i = 0; i < NumLanes; i++) if (lanes[i] == 0) lanes[i] = 1;
      draw_upper_row();
      copy_rows_down();
      draw_upper_row();
      live_len = clamp_cols(cyc_len_reg);
      grid_ok = 1'b1;
    end
    phase_acc = phase_acc + step;
    ip = phase_acc >> Frac;
    if (ip >= live_len) begin
      ip = ip % live_len;
      live_len = clamp_cols(cyc_len_reg);
      ip = ip % live_len;
      phase_acc = (ip << Frac) | (phase_acc & ((64'd1 << Frac) - 1));
    end
    evol_acc = evol_acc + estep;
    if (evol_acc >> 20) begin
      evol_acc = evol_acc & 64'hFFFFF;
      copy_rows_down();
      draw_upper_row();
    end
    total = noise_value(phase_acc);
    w120 = 120;
    for (int i = 0; i < 5; i++) begin
      if (harm_mask_reg[i]) begin
        case (i)
          0: begin mul = 2; wq = 536870912; w120 += 60; end
          1: begin mul = 3; wq = 357913941; w120 += 40; end
          2: begin mul = 4; wq = 268435456; w120 += 30; end
          3: begin mul = 5; wq = 214748365; w120 += 24; end
          default: begin mul = 8; wq = 134217728; w120 += 15; end
        endcase
        total += round_half_up(noise_value(phase_acc * mul) * wq, 30);
      end
    end
    denom = NormC * w120;
    recip = ((NormNum << 20) + denom / 2) / denom;
    s = round_half_up(total * longint'(recip), 31);
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    return s[SampleW-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] sample check: %s", $realtime, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_len_reg = 5'd4;
      harm_mask_reg = 5'd0;
      seed_lo_reg = 64'h0001000100010001;
      seed_hi_reg = 64'h0001000100010001;
      phase_acc = 0;
      evol_acc = 0;
      for (int i = 0; i < 4; i++) begin
        lanes[i] = seed_lo_reg[16*i +: 16];
        lanes[i + 4] = seed_hi_reg[16*i +: 16];
      end
      for (int c = 0; c < Cols; c++) begin
        lower_row[c] = 0;
        upper_row[c] = 0;
      end
      grid_ok = 1'b0;
      live_len = 4;
      sample_queue.delete();
      errors_o = 0;
      samples_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCycleLen: cyc_len_reg = cfg_data_i[4:0];
          RegHarmMask: harm_mask_reg = cfg_data_i[4:0];
          RegSeedLow:  seed_lo_reg = cfg_data_i;
          RegSeedHigh: seed_hi_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        sample_queue.push_back(next_sample(64'(phase_step_i), 64'(evol_step_i)));
      if (out_valid_i && !out_stall_i) begin
        samples_o++;
        if (sample_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, sample %0d", sample_i));
        end else begin
          logic [SampleW-1:0] want;
          want = sample_queue.pop_front();
          if (sample_i !== want)
            report_mismatch($sformatf("got %0d, expected %0d", sample_i,
                                      $signed(want)));
        end
      end
    end
  end

endmodule

[test/tb_looping_simplex_noise_oscillator.sv]
// Testbench top for the looping simplex noise oscillator: stimulus and verdict.
`timescale 1ns / 1ps
module tb_looping_simplex_noise_oscillator;
  import lsno_pkg::*;

  // With every harmonic enabled and the receiver stalling more than half the
  // time, this limit still leaves a wide margin over the slowest correct run
  // of about 1,200 transactions.
  localparam longint CycleLimit = 64'd60000000;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [1:0]                cfg_idx_i = RegCycleLen;
  logic [63:0]               cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [StepW-1:0]          phase_step_i = '0;
  logic [EvolW-1:0]          evol_step_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] sample_o;

  int     pending, errors, samples;
  int     send_idle_pct = 10;
  int     recv_stall_pct = 57;
  int     ticks_sent = 0;
  int     masks_seen = 0;
  longint cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  looping_simplex_noise_oscillator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .phase_step_i, .evol_step_i,
    .out_valid_o, .out_stall_i, .sample_o
  );

  lsno_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .phase_step_i, .evol_step_i,
    .out_valid_i(out_valid_o), .out_stall_i, .sample_i(sample_o),
    .pending_o(pending), .errors_o(errors), .samples_o(samples)
  );

  // The receiver stalls at random; the rate follows the current idling mode.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d samples still outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sends one tick. Random idle cycles go in front of it, then valid stays up
  // with a steady payload until the block takes the transaction.
  task automatic send_tick(logic [StepW-1:0] step, logic [EvolW-1:0] evol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    phase_step_i <= step;
    evol_step_i <= evol;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
    // Switch the idling pattern by thirds of the run.
    if (ticks_sent == 383) begin
      send_idle_pct = 57;
      recv_stall_pct = 10;
    end else if (ticks_sent == 766) begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  // Registers only change once every sample in flight has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly small steps keep the waveform smooth; a few cover the full width.
  task automatic random_tick();
    logic [StepW-1:0] step;
    logic [EvolW-1:0] evol;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: step = StepW'($urandom_range(0, 1 << 18));
      6, 7:             step = StepW'($urandom_range(0, 1 << 21));
      8:                step = StepW'($urandom);
      default:          step = ($urandom_range(1) != 0) ? '1 : '0;
    endcase
    case ($urandom_range(7))
      0:       evol = '0;
      1, 2:    evol = EvolW'($urandom);
      3:       evol = '1;
      default: evol = EvolW'($urandom_range(0, 1 << 17));
    endcase
    send_tick(step, evol);
  endtask

  initial begin
    int lens[8];
    int masks[8];
    int counts[8];
    lens   = '{16, 2, 0, 31, 7, 1, 20, 9};
    masks  = '{0, 31, 5, 16, 10, 1, 27, 0};
    counts = '{180, 60, 150, 170, 140, 170, 100, 160};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Seeds only count before the first tick; one low lane is zero so the
    // forced-to-one rule is exercised.
    write_reg(RegSeedLow, {16'($urandom), 16'h0000, 16'($urandom), 16'($urandom)});
    write_reg(RegSeedHigh, {$urandom, $urandom});
    write_reg(RegCycleLen, 64'd4);
    write_reg(RegHarmMask, 64'd0);

    // Directed ticks: field extremes, exact wrap points and evolution wraps.
    send_tick('0, '0);
    send_tick(24'h080000, 20'h40000);
    send_tick(24'h400000, '0);
    send_tick('1, '1);
    send_tick(24'h0FFFFF, 20'h00001);
    send_tick(24'h100000, 20'hFFFFF);
    send_tick('0, 20'h80000);
    send_tick(24'h800000, 20'h7FFFF);
    send_tick(24'h000001, '0);
    // A new length only applies at the next wrap, so change it mid-stream.
    wait_drained();
    write_reg(RegCycleLen, 64'd3);
    send_tick(24'h040000, 20'h10000);
    send_tick(24'h300000, 20'h10000);
    send_tick(24'hF00000, 20'h10000);
    wait_drained();
    write_reg(RegHarmMask, 64'd31);
    send_tick(24'h012345, 20'h0ABCD);
    send_tick('1, '1);
    send_tick(24'h0C0000, 20'hF0000);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      // Upper data bits are junk on purpose; only five bits are kept.
      write_reg(RegCycleLen, {$urandom, 27'($urandom), 5'(lens[p])});
      write_reg(RegHarmMask, {$urandom, 27'($urandom),
                              5'((p == 7) ? $urandom_range(31) : masks[p])});
      // Late seed writes must not disturb the running grid.
      if (p == 3) begin
        write_reg(RegSeedLow, {$urandom, $urandom});
        write_reg(RegSeedHigh, 64'd0);
      end
      masks_seen++;
      for (int i = 0; i < counts[p]; i++) random_tick();
    end

    wait_drained();
    repeat (200) @(posedge clk_i);

    $display("covered %0d ticks over %0d register settings, %0d samples checked",
             ticks_sent, masks_seen + 3, samples);
    $display("lengths 2 to 16 incl. clamped values, every harmonic layer, three idling modes");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
